### hw/rtl/dpbp_pkg.sv
package dpbp_pkg;

  // Pixel position counters
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned CMP_W      = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;

  // Register widths
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned CENTER_W   = 16;

  // Datapath widths
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned Z_W        = 32;
  localparam int unsigned COORD_W    = 40;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  // offset magnitude |count*16 - center|
  localparam int unsigned DIFF_W     = (COORD_BITS + 4 > CENTER_W) ? COORD_BITS + 4 : CENTER_W;
  // hi word of offset*z, and hi*recip + (lo*recip >> 32)
  localparam int unsigned MAG_HI_W   = DIFF_W;
  localparam int unsigned ACC_W      = DIFF_W + 33;
  localparam int unsigned RES_W      = ACC_W - 4;

  localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] NEG_MAG = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECIP_DEPTH = 3'd0,
    REG_CENTER_X    = 3'd1,
    REG_CENTER_Y    = 3'd2,
    REG_RECIP_FX    = 3'd3,
    REG_RECIP_FY    = 3'd4,
    REG_WIDTH       = 3'd5,
    REG_HEIGHT      = 3'd6
  } cfg_reg_e;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_XD   = 8'b0000_0010,
    ST_XL   = 8'b0000_0100,
    ST_XH   = 8'b0000_1000,
    ST_YD   = 8'b0001_0000,
    ST_YL   = 8'b0010_0000,
    ST_YH   = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } seq_state_e;

  // Apply the sign to a truncated magnitude and saturate to 40 signed bits.
  function automatic logic [COORD_W-1:0] sat_coord(input logic neg,
                                                   input logic [RES_W-1:0] res);
    logic [COORD_W-1:0] mag;
    logic [COORD_W-1:0] out;
    begin
      if (neg) begin
        mag = (res > RES_W'(NEG_MAG)) ? NEG_MAG : res[COORD_W-1:0];
        out = COORD_W'(0) - mag;
      end else begin
        out = (res > RES_W'(POS_MAX)) ? POS_MAX : res[COORD_W-1:0];
      end
      return out;
    end
  endfunction

  // Wrap limit of a counter: a size of zero or above the counter span acts as the span.
  function automatic logic [CMP_W-1:0] size_limit(input logic [SIZE_W-1:0] size);
    logic [CMP_W-1:0] span;
    logic [CMP_W-1:0] ext;
    begin
      span = CMP_W'(1) << COORD_BITS;
      ext  = CMP_W'(size);
      return ((size == '0) || (ext > span)) ? span : ext;
    end
  endfunction

endpackage

### hw/rtl/depth_pixel_backprojection.sv
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+------------------------------------------
// pixel in  | in_valid_i / in_stall_o     | depth_raw_i, pixel_blue/green/red_i
// point out | out_valid_o / out_stall_i   | point_x/y/z_o, out_red/green/blue_o
// config    | cfg_we_i (no wait)          | cfg_index_i, cfg_wdata_i
//
// A pixel with nonzero depth steps through XD, XL, XH, YD, YL, YH and FIN: one
// shared 32x32 multiplier with a registered product is used seven times (z, then
// offset*z, lo*recip and hi*recip for each lateral axis). A zero-depth pixel gives no point.
// The point goes into an output register, so the next pixel starts while it waits.
// A stalled output only holds the final step once the output register is still full.
// Reset (rst_ni low, asynchronous) loads the register defaults and zeroes counters.
module depth_pixel_backprojection
  import dpbp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  // pixel input
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [DEPTH_W-1:0]       depth_raw_i,
  input  logic [COLOR_W-1:0]       pixel_blue_i,
  input  logic [COLOR_W-1:0]       pixel_green_i,
  input  logic [COLOR_W-1:0]       pixel_red_i,
  // point output
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [COORD_W-1:0] point_x_o,
  output logic signed [COORD_W-1:0] point_y_o,
  output logic [Z_W-1:0]           point_z_o,
  output logic [COLOR_W-1:0]       out_red_o,
  output logic [COLOR_W-1:0]       out_green_o,
  output logic [COLOR_W-1:0]       out_blue_o
);

  // Configuration registers
  logic [CFG_W-1:0]    recip_depth_q;
  logic [CENTER_W-1:0] center_x_q;
  logic [CENTER_W-1:0] center_y_q;
  logic [CFG_W-1:0]    recip_fx_q;
  logic [CFG_W-1:0]    recip_fy_q;
  logic [SIZE_W-1:0]   width_q;
  logic [SIZE_W-1:0]   height_q;

  // Sequencer and counters
  seq_state_e          state_q, state_d;
  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;

  // Datapath
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   prod_q;
  logic [DIFF_W-1:0]   diff_x_q, diff_y_q;
  logic [DIFF_W-1:0]   diff_x_d, diff_y_d;
  logic                neg_x_q, neg_y_q;
  logic                neg_x_d, neg_y_d;
  logic [Z_W-1:0]      z_q;
  logic [MAG_HI_W-1:0] mag_hi_q;
  logic [MUL_W-1:0]    plo_hi_q;
  logic [COORD_W-1:0]  x_q;
  logic [COLOR_W-1:0]  red_q, green_q, blue_q;
  logic [ACC_W-1:0]    acc;
  logic [COORD_W-1:0]  coord;

  // Output register
  logic                out_valid_q;
  logic                out_free;
  logic                in_xfer;
  logic                out_xfer;
  logic                out_load;

  logic [DIFF_W-1:0]   pos_x, pos_y;
  logic [DIFF_W-1:0]   cen_x, cen_y;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_FIN) && out_free;
  assign out_valid_o = out_valid_q;

  // Offsets from the principal point, Q.4, split into sign and magnitude
  assign pos_x = DIFF_W'({col_q, 4'b0000});
  assign pos_y = DIFF_W'({row_q, 4'b0000});
  assign cen_x = DIFF_W'(center_x_q);
  assign cen_y = DIFF_W'(center_y_q);

  always_comb begin
    neg_x_d  = cen_x > pos_x;
    neg_y_d  = cen_y > pos_y;
    diff_x_d = neg_x_d ? (cen_x - pos_x) : (pos_x - cen_x);
    diff_y_d = neg_y_d ? (cen_y - pos_y) : (pos_y - cen_y);
  end

  // Counter advance: wrap at the size limit, also when already beyond a shrunk size
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_xfer) begin
      if (CMP_W'(col_q) + CMP_W'(1) >= size_limit(width_q)) begin
        col_d = '0;
        if (CMP_W'(row_q) + CMP_W'(1) >= size_limit(height_q)) begin
          row_d = '0;
        end else begin
          row_d = row_q + COORD_BITS'(1);
        end
      end else begin
        col_d = col_q + COORD_BITS'(1);
      end
    end
  end

  // Shared multiplier operand select; the product is registered every cycle
  always_comb begin
    case (state_q)
      ST_IDLE: begin
        mul_a = MUL_W'(depth_raw_i);
        mul_b = recip_depth_q;
      end
      ST_XD: begin
        mul_a = MUL_W'(diff_x_q);
        mul_b = prod_q[Z_W+15:16];
      end
      ST_XL: begin
        mul_a = prod_q[MUL_W-1:0];
        mul_b = recip_fx_q;
      end
      ST_XH: begin
        mul_a = MUL_W'(mag_hi_q);
        mul_b = recip_fx_q;
      end
      ST_YD: begin
        mul_a = MUL_W'(diff_y_q);
        mul_b = z_q;
      end
      ST_YL: begin
        mul_a = prod_q[MUL_W-1:0];
        mul_b = recip_fy_q;
      end
      ST_YH, ST_FIN: begin
        // FIN repeats the last product so the y sum holds during an output stall
        mul_a = MUL_W'(mag_hi_q);
        mul_b = recip_fy_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // hi*recip + (lo*recip >> 32), then drop four bits to get Q.16
  assign acc   = ACC_W'(prod_q[MAG_HI_W+MUL_W-1:0]) + ACC_W'(plo_hi_q);
  assign coord = sat_coord((state_q == ST_YD) ? neg_x_q : neg_y_q, acc[ACC_W-1:4]);

  always_comb begin
    case (state_q)
      ST_IDLE: state_d = (in_xfer && (depth_raw_i != '0)) ? ST_XD : ST_IDLE;
      ST_XD:   state_d = ST_XL;
      ST_XL:   state_d = ST_XH;
      ST_XH:   state_d = ST_YD;
      ST_YD:   state_d = ST_YL;
      ST_YL:   state_d = ST_YH;
      ST_YH:   state_d = ST_FIN;
      ST_FIN:  state_d = out_free ? ST_IDLE : ST_FIN;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      col_q         <= '0;
      row_q         <= '0;
      out_valid_q   <= 1'b0;
      recip_depth_q <= CFG_W'(4294967);
      center_x_q    <= CENTER_W'(5208);
      center_y_q    <= CENTER_W'(4056);
      recip_fx_q    <= CFG_W'(8291442);
      recip_fy_q    <= CFG_W'(8275467);
      width_q       <= SIZE_W'(640);
      height_q      <= SIZE_W'(480);
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_RECIP_DEPTH: recip_depth_q <= cfg_wdata_i;
          REG_CENTER_X:    center_x_q    <= cfg_wdata_i[CENTER_W-1:0];
          REG_CENTER_Y:    center_y_q    <= cfg_wdata_i[CENTER_W-1:0];
          REG_RECIP_FX:    recip_fx_q    <= cfg_wdata_i;
          REG_RECIP_FY:    recip_fy_q    <= cfg_wdata_i;
          REG_WIDTH:       width_q       <= cfg_wdata_i[SIZE_W-1:0];
          REG_HEIGHT:      height_q      <= cfg_wdata_i[SIZE_W-1:0];
          default: ;  // drop writes to unused indexes
        endcase
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (in_xfer) begin
      diff_x_q <= diff_x_d;
      diff_y_q <= diff_y_d;
      neg_x_q  <= neg_x_d;
      neg_y_q  <= neg_y_d;
      red_q    <= pixel_red_i;
      green_q  <= pixel_green_i;
      blue_q   <= pixel_blue_i;
    end
    if (state_q == ST_XD) begin
      z_q <= prod_q[Z_W+15:16];
    end
    if ((state_q == ST_XL) || (state_q == ST_YL)) begin
      mag_hi_q <= prod_q[MAG_HI_W+MUL_W-1:MUL_W];
    end
    if ((state_q == ST_XH) || (state_q == ST_YH)) begin
      plo_hi_q <= prod_q[PROD_W-1:MUL_W];
    end
    if (state_q == ST_YD) begin
      x_q <= coord;
    end
    if (out_load) begin
      point_x_o   <= x_q;
      point_y_o   <= coord;
      point_z_o   <= z_q;
      out_red_o   <= red_q;
      out_green_o <= green_q;
      out_blue_o  <= blue_q;
    end
  end

  // Assertions
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_zero_depth_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (depth_raw_i == '0) |=> (state_q == ST_IDLE))
    else $error("zero-depth pixel started a point");

  a_depth_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (depth_raw_i != '0) |=> (state_q == ST_XD))
    else $error("nonzero-depth pixel did not start a point");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && out_free |=> out_valid_q && (state_q == ST_IDLE))
    else $error("final step did not load the output register");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && !out_free |=> (state_q == ST_FIN) && $stable(plo_hi_q))
    else $error("final step lost its result during an output stall");

endmodule

### bench/backprojection_checker.sv
module backprojection_checker
  import dpbp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [DEPTH_W-1:0]        depth_raw_i,
  input  logic [COLOR_W-1:0]        pixel_blue_i,
  input  logic [COLOR_W-1:0]        pixel_green_i,
  input  logic [COLOR_W-1:0]        pixel_red_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic [Z_W-1:0]            point_z_i,
  input  logic [COLOR_W-1:0]        out_red_i,
  input  logic [COLOR_W-1:0]        out_green_i,
  input  logic [COLOR_W-1:0]        out_blue_i,
  output int                        mismatches_o,
  output int                        pending_o,
  output int                        checked_o
);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [Z_W-1:0]            z;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
  } point_t;

  point_t expected_points[$];

  // Camera settings as the block should hold them
  logic [31:0]           z_scale;
  logic [CENTER_W-1:0]   principal_col;
  logic [CENTER_W-1:0]   principal_row;
  logic [31:0]           inv_focal_col;
  logic [31:0]           inv_focal_row;
  logic [SIZE_W-1:0]     frame_cols;
  logic [SIZE_W-1:0]     frame_rows;

  // Raster position of the next pixel
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;

  function automatic int wrap_span(input logic [SIZE_W-1:0] size);
    int span;
    span = 1 << COORD_BITS;
    return ((size == '0) || (int'(size) > span)) ? span : int'(size);
  endfunction

  // (count*16 - center) * z * recip >> 36, truncated toward zero, saturated to 40 signed bits
  function automatic logic [COORD_W-1:0] lateral_offset(input logic [COORD_BITS-1:0] count,
                                                        input logic [CENTER_W-1:0]  center,
                                                        input logic [31:0]          z,
                                                        input logic [31:0]          recip);
    logic [23:0]  pos;
    logic [23:0]  diff;
    logic         neg;
    logic [111:0] prod;
    logic [75:0]  mag;
    pos  = 24'(count) << 4;
    neg  = 24'(center) > pos;
    diff = neg ? (24'(center) - pos) : (pos - 24'(center));
    prod = 112'(diff) * 112'(z) * 112'(recip);
    mag  = prod[111:36];
    if (neg) begin
      if (mag > 76'(NEG_MAG)) mag = 76'(NEG_MAG);
      return COORD_W'(0) - mag[COORD_W-1:0];
    end
    if (mag > 76'(POS_MAX)) mag = 76'(POS_MAX);
    return mag[COORD_W-1:0];
  endfunction

  function automatic point_t project_pixel(input logic [DEPTH_W-1:0] depth,
                                           input logic [COLOR_W-1:0] red,
                                           input logic [COLOR_W-1:0] green,
                                           input logic [COLOR_W-1:0] blue);
    logic [47:0] scaled;
    point_t      p;
    scaled  = 48'(depth) * 48'(z_scale);
    p.z     = scaled[47:16];
    p.x     = lateral_offset(pixel_col, principal_col, p.z, inv_focal_col);
    p.y     = lateral_offset(pixel_row, principal_row, p.z, inv_focal_row);
    p.red   = red;
    p.green = green;
    p.blue  = blue;
    return p;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    point_t got;
    point_t want;
    if (!rst_ni) begin
      z_scale       = 32'd4294967;
      principal_col = 16'd5208;
      principal_row = 16'd4056;
      inv_focal_col = 32'd8291442;
      inv_focal_row = 32'd8275467;
      frame_cols    = 13'd640;
      frame_rows    = 13'd480;
      pixel_col     = '0;
      pixel_row     = '0;
      expected_points.delete();
      mismatches_o  = 0;
      checked_o     = 0;
    end else begin
      // compare first: a point leaving now never belongs to a pixel entering now
      if (out_valid_i && !out_stall_i) begin
        got = '{point_x_i, point_y_i, point_z_i, out_red_i, out_green_i, out_blue_i};
        if (expected_points.size() == 0) begin
          $error("point (x=%0d y=%0d z=%0d) with no pixel waiting for it",
                 got.x, got.y, got.z);
          mismatches_o++;
        end else begin
          want = expected_points.pop_front();
          check_field("point_x", longint'(want.x), longint'(got.x));
          check_field("point_y", longint'(want.y), longint'(got.y));
          check_field("point_z", longint'(want.z), longint'(got.z));
          check_field("out_red", longint'(want.red), longint'(got.red));
          check_field("out_green", longint'(want.green), longint'(got.green));
          check_field("out_blue", longint'(want.blue), longint'(got.blue));
          checked_o++;
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_RECIP_DEPTH: z_scale       = cfg_wdata_i;
          REG_CENTER_X:    principal_col = cfg_wdata_i[CENTER_W-1:0];
          REG_CENTER_Y:    principal_row = cfg_wdata_i[CENTER_W-1:0];
          REG_RECIP_FX:    inv_focal_col = cfg_wdata_i;
          REG_RECIP_FY:    inv_focal_row = cfg_wdata_i;
          REG_WIDTH:       frame_cols    = cfg_wdata_i[SIZE_W-1:0];
          REG_HEIGHT:      frame_rows    = cfg_wdata_i[SIZE_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (depth_raw_i != '0)
          expected_points.insert(expected_points.size(),
                                 project_pixel(depth_raw_i, pixel_red_i,
                                               pixel_green_i, pixel_blue_i));
        // advance the raster position, zero depth included
        if (int'(pixel_col) + 1 >= wrap_span(frame_cols)) begin
          pixel_col = '0;
          if (int'(pixel_row) + 1 >= wrap_span(frame_rows)) pixel_row = '0;
          else pixel_row = pixel_row + COORD_BITS'(1);
        end else begin
          pixel_col = pixel_col + COORD_BITS'(1);
        end
      end
    end
    pending_o = expected_points.size();
  end

endmodule

### bench/testbench.sv
module testbench;
  import dpbp_pkg::*;

  // Cycles to let a pixel with no point finish before touching the registers
  localparam int SETTLE_CYCLES = 24;
  localparam int NUM_REGS      = int'(REG_HEIGHT) + 1;
  localparam int PHASES        = 6;
  localparam int PHASE_PIXELS  = 203;
  // Index past the last register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic [DEPTH_W-1:0]        depth_raw;
  logic [COLOR_W-1:0]        pixel_blue;
  logic [COLOR_W-1:0]        pixel_green;
  logic [COLOR_W-1:0]        pixel_red;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [Z_W-1:0]            point_z;
  logic [COLOR_W-1:0]        out_red;
  logic [COLOR_W-1:0]        out_green;
  logic [COLOR_W-1:0]        out_blue;

  int mismatches;
  int points_pending;
  int points_checked;
  int pixels_sent;
  int settings_applied;
  // Odds of an idle burst before a pixel: one in gap_odds, zero for none
  int gap_odds;
  // Set for the closing stretch: no idle bursts on either side
  logic calm;

  // Register values to program next, indexed by register
  logic [CFG_W-1:0] shadow [NUM_REGS];

  depth_pixel_backprojection i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .depth_raw_i   (depth_raw),
    .pixel_blue_i  (pixel_blue),
    .pixel_green_i (pixel_green),
    .pixel_red_i   (pixel_red),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .point_x_o     (point_x),
    .point_y_o     (point_y),
    .point_z_o     (point_z),
    .out_red_o     (out_red),
    .out_green_o   (out_green),
    .out_blue_o    (out_blue)
  );

  backprojection_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .depth_raw_i   (depth_raw),
    .pixel_blue_i  (pixel_blue),
    .pixel_green_i (pixel_green),
    .pixel_red_i   (pixel_red),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .point_z_i     (point_z),
    .out_red_i     (out_red),
    .out_green_i   (out_green),
    .out_blue_i    (out_blue),
    .mismatches_o  (mismatches),
    .pending_o     (points_pending),
    .checked_o     (points_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(8 * 800_000);
    $display("timeout with %0d points still outstanding", points_pending);
    $display("testbench NOT OK");
    $finish;
  end

  // Receiver: alternate free runs and stall bursts; hold stall low once calm
  initial begin
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
                                            : $urandom_range(1, 20)) @(posedge clk);
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // Present one pixel, maybe after an idle burst, and hold it until the transfer
  task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic [COLOR_W-1:0] blue,
                            input logic [COLOR_W-1:0] green, input logic [COLOR_W-1:0] red);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    depth_raw   <= depth;
    pixel_blue  <= blue;
    pixel_green <= green;
    pixel_red   <= red;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Drop valid, wait for every point owed, then let a pointless pixel drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every register from the shadow copy, then poke the unused index
  task automatic program_camera();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= shadow[i];
      @(posedge clk);
    end
    cfg_index <= REG_SPARE;
    cfg_wdata <= $urandom();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  function automatic logic [CFG_W-1:0] pick_recip();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return $urandom();
      2:       return CFG_W'($urandom_range(1, 255));
      default: return CFG_W'($urandom_range(2_000_000, 20_000_000));
    endcase
  endfunction

  // Mostly small frames so rows wrap often; junk above the size field must be dropped
  function automatic logic [CFG_W-1:0] pick_size();
    logic [SIZE_W-1:0] sz;
    case ($urandom_range(0, 7))
      0:       sz = 13'd1;
      1:       sz = '0;
      2:       sz = 13'd4096;
      3:       sz = SIZE_W'($urandom_range(4097, 8191));
      default: sz = SIZE_W'($urandom_range(2, 24));
    endcase
    return ($urandom() & ~CFG_W'({SIZE_W{1'b1}})) | CFG_W'(sz);
  endfunction

  // Centers near the small frames give both signs of offset
  function automatic logic [CFG_W-1:0] pick_center();
    logic [CENTER_W-1:0] c;
    c = $urandom_range(0, 1) ? CENTER_W'($urandom_range(0, 400)) : CENTER_W'($urandom());
    return ($urandom() & 32'hFFFF_0000) | CFG_W'(c);
  endfunction

  initial begin
    logic [DEPTH_W-1:0] depth_pick;
    pixels_sent      = 0;
    settings_applied = 0;
    gap_odds         = 3;
    calm             = 1'b0;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_RECIP_DEPTH;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    depth_raw   <= '0;
    pixel_blue  <= '0;
    pixel_green <= '0;
    pixel_red   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: smallest and largest depth, a hole, color extremes
    send_pixel(16'd1, 8'h00, 8'h00, 8'h00);
    send_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'd0, 8'hAA, 8'h55, 8'hAA);
    send_pixel(16'd1000, 8'h55, 8'hAA, 8'h55);
    wait_idle();

    // Largest scales, center row past every row, sizes of zero and beyond the span
    shadow[REG_RECIP_DEPTH] = '1;
    shadow[REG_CENTER_X]    = '0;
    shadow[REG_CENTER_Y]    = '1;
    shadow[REG_RECIP_FX]    = '1;
    shadow[REG_RECIP_FY]    = '1;
    shadow[REG_WIDTH]       = '0;
    shadow[REG_HEIGHT]      = '1;
    program_camera();
    send_pixel(16'hFFFF, 8'h12, 8'h34, 8'h56);
    send_pixel(16'd1, 8'h9A, 8'hBC, 8'hDE);

    // Walk the column counter past column 128 with holes; the pixel after the holes saturates x
    gap_odds = 8;
    for (int i = 0; i < 200; i++)
      send_pixel('0, COLOR_W'($urandom()), COLOR_W'($urandom()), COLOR_W'($urandom()));
    send_pixel(16'hFFFF, 8'h01, 8'h80, 8'hFE);
    for (int i = 0; i < 20; i++)
      send_pixel('0, COLOR_W'($urandom()), COLOR_W'($urandom()), COLOR_W'($urandom()));
    wait_idle();

    // Shrink the row below the current column: the next advance must wrap
    shadow[REG_WIDTH]    = 32'hABCD_E007;
    shadow[REG_CENTER_X] = 32'h5A5A_0C80;
    gap_odds = 3;
    program_camera();
    send_pixel(16'd4660, 8'h0F, 8'hF0, 8'h3C);
    send_pixel(16'd22136, 8'hC3, 8'h66, 8'h99);
    send_pixel(16'h8000, 8'h7F, 8'h80, 8'h01);
    wait_idle();

    // Everything at its minimum: one-pixel frame, zero scales
    shadow[REG_RECIP_DEPTH] = '0;
    shadow[REG_CENTER_X]    = '0;
    shadow[REG_CENTER_Y]    = '0;
    shadow[REG_RECIP_FX]    = '0;
    shadow[REG_RECIP_FY]    = '0;
    shadow[REG_WIDTH]       = 32'd1;
    shadow[REG_HEIGHT]      = 32'd1;
    program_camera();
    send_pixel(16'hFFFF, 8'hFF, 8'h00, 8'hFF);
    send_pixel(16'd0, 8'h00, 8'hFF, 8'h00);
    send_pixel(16'd1, 8'h80, 8'h7F, 8'h80);
    wait_idle();

    // Random phases: fresh settings each time, the last one with no idling
    for (int p = 0; p < PHASES; p++) begin
      shadow[REG_RECIP_DEPTH] = ($urandom_range(0, 3) == 0) ? pick_recip()
                                : CFG_W'($urandom_range(1_000_000, 70_000_000));
      shadow[REG_CENTER_X]    = pick_center();
      shadow[REG_CENTER_Y]    = pick_center();
      shadow[REG_RECIP_FX]    = pick_recip();
      shadow[REG_RECIP_FY]    = pick_recip();
      shadow[REG_WIDTH]       = pick_size();
      shadow[REG_HEIGHT]      = pick_size();
      gap_odds = $urandom_range(0, 4);
      calm     = (p == PHASES - 1);
      program_camera();
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        case ($urandom_range(0, 9))
          0, 1:    depth_pick = '0;
          2:       depth_pick = '1;
          3:       depth_pick = 16'd1;
          4:       depth_pick = DEPTH_W'($urandom_range(1, 255));
          default: depth_pick = DEPTH_W'($urandom_range(1, 65535));
        endcase
        send_pixel(depth_pick, COLOR_W'($urandom()), COLOR_W'($urandom()),
                   COLOR_W'($urandom()));
      end
      wait_idle();
    end

    $display("%0d pixels over %0d register settings, %0d points compared field by field",
             pixels_sent, settings_applied, points_checked);
    if (mismatches == 0 && points_pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
